>>> hdl/sgt_pkg.sv
// ----------------------------------------------------------------------------
// sgt_pkg
// Shared types and constants for the sequence gap tracker: field widths,
// action codes, the queued item record and the result record.
// ----------------------------------------------------------------------------
package sgt_pkg;

  // Field widths
  localparam int SEQ_W   = 64;
  localparam int CNT_W   = 16;
  localparam int BLEN_W  = 11;
  localparam int ACT_W   = 2;

  // Stream data widths (packed fields padded to whole bytes)
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 80;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_DROP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FWD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_HOLD = 2'd2;

  // Queue between front and back
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  // Header as it waits in the queue, with its end sequence precomputed
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [CNT_W-1:0]  cnt;
    logic [BLEN_W-1:0] blen;
    logic [SEQ_W-1:0]  seq_end;
  } item_t;

  // Decision for one header
  typedef struct packed {
    logic              gap_overflow;
    logic [BLEN_W-1:0] retx_bytes;
    logic [SEQ_W-1:0]  retx_first_seq;
    logic              retx_request;
    logic              flush_held;
    logic [ACT_W-1:0]  action;
  } result_t;

endpackage

>>> hdl/sequence_gap_tracker.sv
// ----------------------------------------------------------------------------
// sequence_gap_tracker
// Packet-level sequence gap detection for a sequenced multicast feed.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one packet header per transaction (sequence number, message
//           count, byte length). out_* : one decision per header, in order.
//   cfg_* : writing cfg_wr_data sets the sequence number expected next;
//           write only while no header is in flight.
// An accepted header is written into the queue, then decided by the back end
//   and registered in the output register before it shows on out_*.
// Throughput: one header per cycle while the receiver takes each decision.
//   The tracking state (expected number, lost window, held flag) is updated as
//   each header leaves the queue, so it sees the state left by the one before it.
// A two-entry queue sits between the front end and the back end; when the
//   receiver stalls, the output register holds its transaction and the
//   queue still takes up to two more headers before in_tready drops.
// Reset (rst_n low, synchronous): expected number 1, lost set empty, no
//   held packets, queue and output register empty.
// ----------------------------------------------------------------------------
module sequence_gap_tracker #(
  parameter int LOST_WINDOW = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // cfg: start sequence number
  input  logic                               cfg_wr_en,
  input  logic [sgt_pkg::SEQ_W-1:0]          cfg_wr_data,
  // in_tdata: seq_num[63:0], msg_count[79:64], byte_len[90:80], zero[95:91]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sgt_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata: action[1:0], flush_held[2], retx_request[3],
  //            retx_first_seq[67:4], retx_bytes[78:68], gap_overflow[79]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sgt_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic              q_valid;
  logic              q_pop;
  sgt_pkg::item_t    q_item;
  sgt_pkg::result_t  res;

  sgt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_seq   (in_tdata[63:0]),
    .in_cnt   (in_tdata[79:64]),
    .in_blen  (in_tdata[90:80]),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  sgt_back #(
    .LOST_WINDOW (LOST_WINDOW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res)
  );

  // Output packing, action in the lowest bits, gap_overflow in the highest
  assign out_tdata = {res.gap_overflow, res.retx_bytes, res.retx_first_seq,
                      res.retx_request, res.flush_held, res.action};

endmodule

>>> hdl/sgt_front.sv
// ----------------------------------------------------------------------------
// sgt_front
// Accepts packet headers, precomputes the sequence number following the
// packet and queues the header for the back end.
// ----------------------------------------------------------------------------
module sgt_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sgt_pkg::SEQ_W-1:0]    in_seq,
  input  logic [sgt_pkg::CNT_W-1:0]    in_cnt,
  input  logic [sgt_pkg::BLEN_W-1:0]   in_blen,
  output logic                         q_valid,
  output sgt_pkg::item_t               q_item,
  input  logic                         q_pop
);

  sgt_pkg::item_t                  q_r [sgt_pkg::QDEPTH];
  logic [sgt_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [sgt_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [sgt_pkg::QCOUNT_W-1:0]    count_r, count_nxt;
  sgt_pkg::item_t                  new_item;
  logic                            push;

  // Precompute: end of the packet's sequence range, wraps modulo 2^64
  always_comb begin
    new_item.seq     = in_seq;
    new_item.cnt     = in_cnt;
    new_item.blen    = in_blen;
    new_item.seq_end = in_seq + sgt_pkg::SEQ_W'(in_cnt);
  end

  assign in_ready = (count_r != sgt_pkg::QCOUNT_W'(sgt_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sgt_pkg::QPTR_W'(sgt_pkg::QDEPTH - 1)) ? '0
                                                                       : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sgt_pkg::QPTR_W'(sgt_pkg::QDEPTH - 1)) ? '0
                                                                       : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage, payload only
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

>>> hdl/sgt_back.sv
// ----------------------------------------------------------------------------
// sgt_back
// Holds the tracking state (expected sequence, lost window, held flag),
// decides forward / hold / drop for each queued header and registers the
// result for the output channel.
// ----------------------------------------------------------------------------
module sgt_back #(
  parameter int LOST_WINDOW = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [sgt_pkg::SEQ_W-1:0]    cfg_wr_data,
  input  logic                         q_valid,
  input  sgt_pkg::item_t               q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sgt_pkg::result_t             out_res
);

  localparam int IW = $clog2(LOST_WINDOW + 1);
  localparam int MW = $clog2(LOST_WINDOW);

  // Bits at or above x within the window
  function automatic logic [LOST_WINDOW-1:0] ge_mask(input logic [63:0] x);
    logic [LOST_WINDOW-1:0] m;
    logic                   in_win;
    in_win = (x < 64'(LOST_WINDOW));
    for (int i = 0; i < LOST_WINDOW; i++) begin
      m[i] = in_win && (IW'(i) >= x[IW-1:0]);
    end
    return m;
  endfunction

  // Bits below x within the window
  function automatic logic [LOST_WINDOW-1:0] lt_mask(input logic [64:0] x);
    logic [LOST_WINDOW-1:0] m;
    logic                   in_win;
    in_win = (x < 65'(LOST_WINDOW));
    for (int i = 0; i < LOST_WINDOW; i++) begin
      m[i] = !in_win || (IW'(i) < x[IW-1:0]);
    end
    return m;
  endfunction

  logic [sgt_pkg::SEQ_W-1:0]   exp_r, exp_nxt;
  logic [sgt_pkg::SEQ_W-1:0]   base_r, base_nxt;
  logic [LOST_WINDOW-1:0]      map_r, map_nxt;
  logic                        held_r, held_nxt;
  logic                        out_valid_r;
  sgt_pkg::result_t            res_r, res_nxt;

  logic                        any_lost;
  logic [sgt_pkg::SEQ_W-1:0]   off;
  logic                        hit;
  logic [LOST_WINDOW-1:0]      clr_mask;
  logic [LOST_WINDOW-1:0]      below;
  logic [LOST_WINDOW-1:0]      map_clr;
  logic [sgt_pkg::SEQ_W-1:0]   base_gap;
  logic [sgt_pkg::SEQ_W-1:0]   s_off;
  logic [sgt_pkg::SEQ_W-1:0]   gap_len;
  logic [sgt_pkg::SEQ_W:0]     gap_end;
  logic [LOST_WINDOW-1:0]      set_mask;
  logic                        ovf;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Window arithmetic for the retransmission and gap cases
  always_comb begin
    any_lost = |map_r;
    off      = q_item.seq - base_r;
    hit      = (off < 64'(LOST_WINDOW)) && map_r[off[MW-1:0]];
    clr_mask = ge_mask(off) & lt_mask({1'b0, off} + 65'(q_item.cnt));
    below    = map_r & lt_mask({1'b0, off});
    map_clr  = map_r & ~clr_mask;

    // a gap into an empty set re-anchors the window at the expected number
    base_gap = any_lost ? base_r : exp_r;
    s_off    = exp_r - base_gap;
    gap_len  = q_item.seq - exp_r;
    gap_end  = {1'b0, s_off} + {1'b0, gap_len};
    if (gap_end[sgt_pkg::SEQ_W]) begin
      set_mask = ge_mask(s_off) | lt_mask({1'b0, gap_end[sgt_pkg::SEQ_W-1:0]});
    end else begin
      set_mask = ge_mask(s_off) & lt_mask(gap_end);
    end
    ovf = (s_off >= 64'(LOST_WINDOW)) || (gap_end > 65'(LOST_WINDOW));
  end

  // Decision and next state
  always_comb begin
    exp_nxt  = exp_r;
    base_nxt = base_r;
    map_nxt  = map_r;
    held_nxt = held_r;
    res_nxt  = '0;
    res_nxt.action = sgt_pkg::ACT_DROP;

    if (q_item.seq == exp_r) begin
      // in order
      exp_nxt = q_item.seq_end;
      if (any_lost) begin
        res_nxt.action = sgt_pkg::ACT_HOLD;
        held_nxt       = 1'b1;
      end else begin
        res_nxt.action     = sgt_pkg::ACT_FWD;
        res_nxt.flush_held = held_r;
        held_nxt           = 1'b0;
      end
    end else if (hit) begin
      // retransmission of a lost number
      map_nxt = map_clr;
      if (below == '0) begin
        res_nxt.action = sgt_pkg::ACT_FWD;
        if (held_r && (map_clr == '0)) begin
          res_nxt.flush_held = 1'b1;
          held_nxt           = 1'b0;
        end
      end else begin
        res_nxt.action = sgt_pkg::ACT_HOLD;
        held_nxt       = 1'b1;
      end
    end else if (q_item.seq > exp_r) begin
      // gap: record lost numbers and request them
      base_nxt               = base_gap;
      map_nxt                = map_r | set_mask;
      exp_nxt                = q_item.seq_end;
      held_nxt               = 1'b1;
      res_nxt.action         = sgt_pkg::ACT_HOLD;
      res_nxt.retx_request   = 1'b1;
      res_nxt.retx_first_seq = exp_r;
      res_nxt.retx_bytes     = q_item.blen;
      res_nxt.gap_overflow   = ovf;
    end
  end

  // Tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= sgt_pkg::SEQ_W'(1);
      base_r <= '0;
      map_r  <= '0;
      held_r <= 1'b0;
    end else if (cfg_wr_en) begin
      exp_r <= cfg_wr_data;
    end else if (q_pop) begin
      exp_r  <= exp_nxt;
      base_r <= base_nxt;
      map_r  <= map_nxt;
      held_r <= held_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> hdl/sgt_checker.sv
// ----------------------------------------------------------------------------
// sgt_checker
// Port-level checks on the sequence gap tracker's result stream, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
module sgt_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [sgt_pkg::OUT_DATA_W-1:0]     out_tdata
);

  // Stalled result transaction stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Action is a defined code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == sgt_pkg::ACT_DROP) ||
                   (out_tdata[1:0] == sgt_pkg::ACT_FWD)  ||
                   (out_tdata[1:0] == sgt_pkg::ACT_HOLD))
    else $error("undefined action code");

  // A gap request always holds the revealing packet
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[1:0] == sgt_pkg::ACT_HOLD)
    else $error("retransmission request without hold");

  // Held packets are released only alongside a forwarded one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == sgt_pkg::ACT_FWD)
    else $error("flush without forward");

  // Request fields and overflow are zero without a request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3] |-> out_tdata[79:4] == '0)
    else $error("request fields set without request");

endmodule

bind sequence_gap_tracker sgt_checker u_sgt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: sequence_gap_tracker testbench
// A queue of packet headers feeds a clocked driver on the in_ stream; a
// clocked monitor takes decisions from the out_ stream and checks every
// field against a local tracker model that is advanced on each accepted
// header. Directed headers cover gaps, retransmission, overflow, duplicates
// and flushing; random streams follow at several start numbers and with
// sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;

  localparam int LOST_WIN   = 64;
  localparam int HOLD_LEN   = 300;
  localparam int WDOG_LIMIT = 2000;

  // Tracker state as the block keeps it
  typedef struct {
    logic [sgt_pkg::SEQ_W-1:0] exp_seq;
    logic [sgt_pkg::SEQ_W-1:0] base;
    logic [LOST_WIN-1:0]       map;
    logic                      held;
  } trk_t;

  // One packet header; sync holds it back until all decisions are in
  typedef struct {
    logic [sgt_pkg::SEQ_W-1:0]  seq;
    logic [sgt_pkg::CNT_W-1:0]  cnt;
    logic [sgt_pkg::BLEN_W-1:0] blen;
    bit                         sync;
  } header_t;

  logic                           clk;
  logic                           rst_n       = 1'b0;
  logic                           cfg_wr_en   = 1'b0;
  logic [sgt_pkg::SEQ_W-1:0]      cfg_wr_data = '0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  // in_tdata: seq_num[63:0], msg_count[79:64], byte_len[90:80], zero[95:91]
  logic [sgt_pkg::IN_DATA_W-1:0]  in_tdata    = '0;
  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  // out_tdata: action[1:0], flush_held[2], retx_request[3],
  //            retx_first_seq[67:4], retx_bytes[78:68], gap_overflow[79]
  logic [sgt_pkg::OUT_DATA_W-1:0] out_tdata;

  header_t          pending_hdrs[$];
  sgt_pkg::result_t expected_verdicts[$];
  trk_t             live_trk;
  trk_t             plan_trk;
  header_t          cur_hdr;

  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 84;
  int unsigned hold_kick     = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned mismatches    = 0;

  sequence_gap_tracker #(.LOST_WINDOW(LOST_WIN)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Decide one header and advance the tracker state
  function automatic sgt_pkg::result_t track_header(inout trk_t st, input header_t h);
    sgt_pkg::result_t          r;
    logic [sgt_pkg::SEQ_W-1:0] off;
    logic [sgt_pkg::SEQ_W-1:0] span_start;
    logic [sgt_pkg::SEQ_W-1:0] gap_len;
    int                        lowest;
    bit                        fwd;
    r      = '0;
    fwd    = 1'b0;
    lowest = 0;
    off    = h.seq - st.base;
    if (h.seq == st.exp_seq) begin
      // in order
      st.exp_seq = st.exp_seq + sgt_pkg::SEQ_W'(h.cnt);
      if (st.map != '0) begin
        r.action = sgt_pkg::ACT_HOLD;
        st.held  = 1'b1;
      end else begin
        r.action = sgt_pkg::ACT_FWD;
        fwd      = 1'b1;
      end
    end else if (off < sgt_pkg::SEQ_W'(LOST_WIN) && st.map[int'(off)]) begin
      // retransmission of a lost number
      for (int i = LOST_WIN - 1; i >= 0; i--)
        if (st.map[i]) lowest = i;
      for (int i = 0; i < LOST_WIN; i++)
        if ((st.base + sgt_pkg::SEQ_W'(i)) - h.seq < sgt_pkg::SEQ_W'(h.cnt))
          st.map[i] = 1'b0;
      if (sgt_pkg::SEQ_W'(lowest) == off) begin
        r.action = sgt_pkg::ACT_FWD;
        fwd      = 1'b1;
      end else begin
        r.action = sgt_pkg::ACT_HOLD;
        st.held  = 1'b1;
      end
    end else if (h.seq > st.exp_seq) begin
      // gap: anchor the window only when nothing is lost yet
      if (st.map == '0) st.base = st.exp_seq;
      span_start = st.exp_seq - st.base;
      gap_len    = h.seq - st.exp_seq;
      if (span_start >= sgt_pkg::SEQ_W'(LOST_WIN) ||
          gap_len > sgt_pkg::SEQ_W'(LOST_WIN) - span_start)
        r.gap_overflow = 1'b1;
      for (int i = 0; i < LOST_WIN; i++)
        if ((st.base + sgt_pkg::SEQ_W'(i)) - st.exp_seq < gap_len) st.map[i] = 1'b1;
      r.retx_request   = 1'b1;
      r.retx_first_seq = st.exp_seq;
      r.retx_bytes     = h.blen;
      st.exp_seq       = h.seq + sgt_pkg::SEQ_W'(h.cnt);
      r.action         = sgt_pkg::ACT_HOLD;
      st.held          = 1'b1;
    end else begin
      r.action = sgt_pkg::ACT_DROP;
    end
    if (fwd && st.held && st.map == '0) begin
      r.flush_held = 1'b1;
      st.held      = 1'b0;
    end
    return r;
  endfunction

  function automatic void field_check(string fname, logic [sgt_pkg::SEQ_W-1:0] want,
                                      logic [sgt_pkg::SEQ_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, fname, want, got);
      mismatches++;
    end
  endfunction

  // Driver: predict on each accepted transaction, then offer the next header
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_verdicts.push_back(track_header(live_trk, cur_hdr));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_hdrs.size() > 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_hdrs[0].sync && expected_verdicts.size() != 0)) begin
          cur_hdr = pending_hdrs.pop_front();
          in_tdata  <= {5'b0, cur_hdr.blen, cur_hdr.cnt, cur_hdr.seq};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each decision, drive out_tready, run the watchdog
  always @(posedge clk) begin
    sgt_pkg::result_t want;
    sgt_pkg::result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = sgt_pkg::result_t'(out_tdata);
        if (expected_verdicts.size() == 0) begin
          $display("%0t: decision with none expected, expected none, actual 0x%0h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          field_check("action", sgt_pkg::SEQ_W'(want.action),
                      sgt_pkg::SEQ_W'(got.action));
          field_check("flush_held", sgt_pkg::SEQ_W'(want.flush_held),
                      sgt_pkg::SEQ_W'(got.flush_held));
          field_check("retx_request", sgt_pkg::SEQ_W'(want.retx_request),
                      sgt_pkg::SEQ_W'(got.retx_request));
          field_check("retx_first_seq", want.retx_first_seq, got.retx_first_seq);
          field_check("retx_bytes", sgt_pkg::SEQ_W'(want.retx_bytes),
                      sgt_pkg::SEQ_W'(got.retx_bytes));
          field_check("gap_overflow", sgt_pkg::SEQ_W'(want.gap_overflow),
                      sgt_pkg::SEQ_W'(got.gap_overflow));
        end
      end
      // long hold-off on request, else random stalls
      if (hold_kick != hold_seen) begin
        hold_seen  <= hold_kick;
        hold_left  <= HOLD_LEN;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_header(input logic [sgt_pkg::SEQ_W-1:0] seq,
                              input logic [sgt_pkg::CNT_W-1:0] cnt,
                              input logic [sgt_pkg::BLEN_W-1:0] blen, input bit sync);
    header_t h;
    h.seq  = seq;
    h.cnt  = cnt;
    h.blen = blen;
    h.sync = sync;
    void'(track_header(plan_trk, h));
    pending_hdrs.push_back(h);
  endtask

  // Mostly well-formed streams: in-order runs, gaps, retransmissions, dups
  task automatic queue_stream(input int n, input int sync_at);
    logic [sgt_pkg::SEQ_W-1:0]  seq;
    logic [sgt_pkg::CNT_W-1:0]  cnt;
    logic [sgt_pkg::BLEN_W-1:0] blen;
    int                         roll;
    int                         idx;
    int                         lo;
    int                         hi;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      blen = ($urandom_range(9) == 0) ? sgt_pkg::BLEN_W'($urandom)
                                      : sgt_pkg::BLEN_W'($urandom_range(1024));
      cnt  = ($urandom_range(9) == 0) ? '0 : sgt_pkg::CNT_W'($urandom_range(1, 8));
      if (plan_trk.map != '0 && roll < 35) begin
        // retransmit: lowest lost, or any lost number
        lo = 0;
        hi = 0;
        for (int i = LOST_WIN - 1; i >= 0; i--)
          if (plan_trk.map[i]) lo = i;
        for (int i = 0; i < LOST_WIN; i++)
          if (plan_trk.map[i]) hi = i;
        if ($urandom_range(1) == 0) begin
          idx = lo;
        end else begin
          idx = $urandom_range(LOST_WIN - 1);
          while (!plan_trk.map[idx]) idx = (idx + 1) % LOST_WIN;
        end
        case ($urandom_range(3))
          0: cnt = '0;
          1: cnt = sgt_pkg::CNT_W'(hi - idx + 1);
          default: cnt = sgt_pkg::CNT_W'($urandom_range(1, 4));
        endcase
        seq = plan_trk.base + sgt_pkg::SEQ_W'(idx);
      end else if (roll < 65) begin
        seq = plan_trk.exp_seq;
      end else if (roll < 82) begin
        if ($urandom_range(7) == 0)
          seq = plan_trk.exp_seq + sgt_pkg::SEQ_W'($urandom_range(50, 90));
        else seq = plan_trk.exp_seq + sgt_pkg::SEQ_W'($urandom_range(1, 12));
      end else if (roll < 94) begin
        seq = plan_trk.exp_seq - sgt_pkg::SEQ_W'($urandom_range(1, 40));
      end else begin
        seq = {$urandom, $urandom};
        cnt = sgt_pkg::CNT_W'($urandom);
      end
      queue_header(seq, cnt, blen, k == sync_at);
    end
  endtask

  task automatic wait_drained();
    while (pending_hdrs.size() != 0 || in_tvalid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Registers change only while nothing is in flight
  task automatic write_start(input logic [sgt_pkg::SEQ_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    live_trk.exp_seq = value;
    plan_trk.exp_seq = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stimulus sequence
  initial begin
    live_trk = '{exp_seq: 64'd1, base: '0, map: '0, held: 1'b0};
    plan_trk = live_trk;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed headers at the reset start number
    queue_header(64'd1, 16'd3, 11'd0, 1'b0);
    queue_header(64'd4, 16'd0, 11'd1024, 1'b0);         // zero count in order
    queue_header(64'd10, 16'd2, 11'h7FF, 1'b0);         // gap, byte length at its maximum
    queue_header(64'd12, 16'd1, 11'd64, 1'b0);          // in order while lost
    queue_header(64'd2, 16'd1, 11'd5, 1'b0);            // duplicate
    queue_header(64'd7, 16'd0, 11'd9, 1'b0);            // retransmit, clears nothing
    queue_header(64'd7, 16'd3, 11'd9, 1'b0);            // retransmit, not lowest
    queue_header(64'd4, 16'd3, 11'd100, 1'b0);          // lowest, releases held
    queue_header(64'd113, 16'd1, 11'd33, 1'b0);         // gap wider than window
    queue_header(64'd90, 16'd2, 11'd1, 1'b0);           // lost outside window
    queue_header(64'd120, 16'd1, 11'd7, 1'b0);          // gap, window stays anchored
    queue_header(64'd13, 16'd64, 11'd12, 1'b0);         // clears all, flush
    queue_header(64'd121, 16'hFFFF, 11'd0, 1'b0);
    queue_header(64'd0, 16'd1, 11'd3, 1'b0);            // sequence zero, behind
    queue_header('1, 16'hFFFF, 11'h7FF, 1'b0);          // all-ones header
    queue_header(64'd65656, 16'd0, 11'd4, 1'b0);        // forward, no flush
    wait_drained();

    // Start at the top of the range, stream wraps
    write_start('1);
    queue_header('1, 16'd3, 11'd20, 1'b0);
    queue_stream(500, -1);
    wait_drained();

    // Start at zero, sender mostly idle, one pause until drained
    send_idle_pct <= 84;
    recv_idle_pct <= 17;
    write_start('0);
    queue_header('0, 16'd2, 11'd8, 1'b0);
    queue_stream(500, 250);
    wait_drained();

    // Random start, no idling, long receiver hold-off to back up the block
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_start({$urandom, $urandom});
    queue_stream(600, 400);
    @(posedge clk);
    hold_kick <= hold_kick + 1;
    wait_drained();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
